### hdl/vtg_pkg.sv
package vtg_pkg;

    localparam int SQ_STEPS   = 15;
    localparam int VEC_W      = 27;
    localparam int MAX_STAGES = 24;
    localparam logic [31:0] HALF_TURN  = 32'h8000_0000;
    localparam logic [15:0] PLANE_TILE = 16'd5120;
    localparam logic signed [15:0] Y_ONE = 16'sd16384;

    localparam logic [1:0] MODE_SPHERE = 2'd0;
    localparam logic [1:0] MODE_CUBE   = 2'd1;
    localparam logic [1:0] MODE_PLANE  = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_SCALE_X = 2'd1;
    localparam logic [1:0] REG_SCALE_Y = 2'd2;
    localparam logic [1:0] REG_SCALE_Z = 2'd3;

    // corner codes: which scale component a cube corner uses
    localparam logic [1:0] CC_ZERO = 2'd0;
    localparam logic [1:0] CC_X    = 2'd1;
    localparam logic [1:0] CC_Y    = 2'd2;
    localparam logic [1:0] CC_Z    = 2'd3;

    typedef struct packed {
        logic [15:0]        vertex_index;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
    } t_vertex;

    typedef struct packed {
        logic [15:0] tex_u;
        logic [15:0] tex_v;
        logic        coord_valid;
    } t_result;

    // request moving through the square root cells
    typedef struct packed {
        logic               vld;
        logic [15:0]        idx;
        logic signed [15:0] px;
        logic signed [15:0] pz;
        logic signed [15:0] py;
        logic [29:0]        rem;
        logic [29:0]        root;
    } t_sq;

    // request moving through the angle cells: two vectors at once
    typedef struct packed {
        logic                    vld;
        logic [15:0]             idx;
        logic signed [VEC_W-1:0] ux;
        logic signed [VEC_W-1:0] uy;
        logic [31:0]             ua;
        logic signed [VEC_W-1:0] vx;
        logic signed [VEC_W-1:0] vy;
        logic [31:0]             va;
    } t_cr;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] a;
        case (i)
            0:  a = 32'h20000000;
            1:  a = 32'h12E4051D;
            2:  a = 32'h09FB385B;
            3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;
            5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;
            7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;
            9:  a = 32'h00145F2E;
            10: a = 32'h000A2F98;
            11: a = 32'h000517CC;
            12: a = 32'h00028BE6;
            13: a = 32'h000145F3;
            14: a = 32'h0000A2F9;
            15: a = 32'h0000517C;
            16: a = 32'h000028BE;
            17: a = 32'h0000145F;
            18: a = 32'h00000A2F;
            19: a = 32'h00000517;
            20: a = 32'h0000028B;
            21: a = 32'h00000145;
            22: a = 32'h000000A2;
            23: a = 32'h00000051;
            default: a = 32'h0;
        endcase
        return a;
    endfunction

    // {u code, v code} for each cube index
    function automatic logic [3:0] cube_code(input logic [4:0] i);
        logic [3:0] c;
        case (i)
            5'd0:  c = {CC_ZERO, CC_ZERO};
            5'd1:  c = {CC_Z, CC_ZERO};
            5'd2:  c = {CC_Z, CC_X};
            5'd3:  c = {CC_ZERO, CC_X};
            5'd4:  c = {CC_ZERO, CC_ZERO};
            5'd5:  c = {CC_Y, CC_ZERO};
            5'd6:  c = {CC_Y, CC_Z};
            5'd7:  c = {CC_ZERO, CC_Z};
            5'd8:  c = {CC_ZERO, CC_X};
            5'd9:  c = {CC_Z, CC_X};
            5'd10: c = {CC_Z, CC_ZERO};
            5'd11: c = {CC_ZERO, CC_ZERO};
            5'd12: c = {CC_ZERO, CC_ZERO};
            5'd13: c = {CC_X, CC_ZERO};
            5'd14: c = {CC_X, CC_Y};
            5'd15: c = {CC_ZERO, CC_Y};
            5'd16: c = {CC_ZERO, CC_ZERO};
            5'd17: c = {CC_Y, CC_ZERO};
            5'd18: c = {CC_Y, CC_Z};
            5'd19: c = {CC_ZERO, CC_Z};
            5'd20: c = {CC_Y, CC_ZERO};
            5'd21: c = {CC_Y, CC_Z};
            5'd22: c = {CC_ZERO, CC_Z};
            5'd23: c = {CC_ZERO, CC_ZERO};
            default: c = {CC_ZERO, CC_ZERO};
        endcase
        return c;
    endfunction

    // {u set, v set} for each plane corner
    function automatic logic [1:0] plane_code(input logic [1:0] i);
        logic [1:0] c;
        case (i)
            2'd0: c = 2'b01;
            2'd1: c = 2'b00;
            2'd2: c = 2'b10;
            2'd3: c = 2'b11;
            default: c = 2'b00;
        endcase
        return c;
    endfunction

endpackage

### hdl/vtg_sqrt_cell.sv
module vtg_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  vtg_pkg::t_sq   i_sq,
    output vtg_pkg::t_sq   o_sq
);

    localparam logic [29:0] BIT = 30'(1) << (2 * (vtg_pkg::SQ_STEPS - 1 - STEP));

    vtg_pkg::t_sq r_sq;
    vtg_pkg::t_sq n_sq;
    logic [29:0]  trial;

    always_comb begin
        n_sq  = i_sq;
        trial = i_sq.root + BIT;
        if (i_sq.rem >= trial) begin
            n_sq.rem  = i_sq.rem - trial;
            n_sq.root = (i_sq.root >> 1) + BIT;
        end else begin
            n_sq.root = i_sq.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq <= '0;
        end else begin
            r_sq <= n_sq;
        end
    end

    assign o_sq = r_sq;

endmodule

### hdl/vtg_cordic_cell.sv
module vtg_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  vtg_pkg::t_cr   i_cr,
    output vtg_pkg::t_cr   o_cr
);

    localparam logic [31:0] ANG = vtg_pkg::atan_turn(STAGE);

    vtg_pkg::t_cr r_cr;
    vtg_pkg::t_cr n_cr;

    always_comb begin
        n_cr = i_cr;
        // turn each vector toward the x axis; a vector on the axis holds
        if (i_cr.uy > 0) begin
            n_cr.ux = i_cr.ux + (i_cr.uy >>> STAGE);
            n_cr.uy = i_cr.uy - (i_cr.ux >>> STAGE);
            n_cr.ua = i_cr.ua + ANG;
        end else if (i_cr.uy < 0) begin
            n_cr.ux = i_cr.ux - (i_cr.uy >>> STAGE);
            n_cr.uy = i_cr.uy + (i_cr.ux >>> STAGE);
            n_cr.ua = i_cr.ua - ANG;
        end
        if (i_cr.vy > 0) begin
            n_cr.vx = i_cr.vx + (i_cr.vy >>> STAGE);
            n_cr.vy = i_cr.vy - (i_cr.vx >>> STAGE);
            n_cr.va = i_cr.va + ANG;
        end else if (i_cr.vy < 0) begin
            n_cr.vx = i_cr.vx - (i_cr.vy >>> STAGE);
            n_cr.vy = i_cr.vy + (i_cr.vx >>> STAGE);
            n_cr.va = i_cr.va - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cr <= '0;
        end else begin
            r_cr <= n_cr;
        end
    end

    assign o_cr = r_cr;

endmodule

### hdl/vertex_texcoord_generator.sv
// Texture coordinate generator: one vertex request in, one (u, v) result out.
// Requests: raise i_start with i_vertex; the request is taken at a clock edge
// where i_start is high and o_busy is low. o_busy is high only in reset and
// in the first cycle after it, so a new request can enter on every cycle.
// Results: o_done strobes for one cycle with o_result; the receiver cannot
// hold results off, so every result must be taken in that cycle.
// Every mode passes the same registers in order: the y clamp and 1 - y^2
// register, 15 square root cells, the register that sets up the two vectors,
// ANGLE_STAGES angle cells, the multiply register and the output register.
// Throughput is one vertex per cycle; each cell holds one request.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx (mode,
// scale x, scale y, scale z). Write only while no request is in flight.
// Reset (synchronous, active low) empties the pipeline, sets mode to none
// and all scales to 1.0.
module vertex_texcoord_generator #(
    parameter int ANGLE_STAGES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  vtg_pkg::t_vertex  i_vertex,
    output logic              o_done,
    output vtg_pkg::t_result  o_result,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data
);

    logic [1:0]  r_mode;
    logic [15:0] r_scale_x;
    logic [15:0] r_scale_y;
    logic [15:0] r_scale_z;
    logic        r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= vtg_pkg::MODE_NONE;
            r_scale_x <= 16'd256;
            r_scale_y <= 16'd256;
            r_scale_z <= 16'd256;
            r_busy    <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    vtg_pkg::REG_MODE:    r_mode    <= i_cfg_data[1:0];
                    vtg_pkg::REG_SCALE_X: r_scale_x <= i_cfg_data;
                    vtg_pkg::REG_SCALE_Y: r_scale_y <= i_cfg_data;
                    vtg_pkg::REG_SCALE_Z: r_scale_z <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign o_busy = r_busy;

    // clamp y and form 1 - y^2 for the root
    vtg_pkg::t_sq       r_s0;
    logic signed [15:0] ycl;
    logic signed [31:0] ysq;

    always_comb begin
        ycl = i_vertex.pos_y;
        if (i_vertex.pos_y > vtg_pkg::Y_ONE) begin
            ycl = vtg_pkg::Y_ONE;
        end else if (i_vertex.pos_y < -vtg_pkg::Y_ONE) begin
            ycl = -vtg_pkg::Y_ONE;
        end
        ysq = ycl * ycl;
    end

    always_ff @(posedge i_clk) begin
        r_s0.idx  <= i_vertex.vertex_index;
        r_s0.px   <= i_vertex.pos_x;
        r_s0.pz   <= i_vertex.pos_z;
        r_s0.py   <= ycl;
        r_s0.rem  <= (30'(1) << 28) - 30'(ysq[29:0]);
        r_s0.root <= 30'd0;
        if (!i_rst_n) begin
            r_s0.vld <= 1'b0;
        end else begin
            r_s0.vld <= i_start && !r_busy;
        end
    end

    vtg_pkg::t_sq w_sq [0:vtg_pkg::SQ_STEPS];
    assign w_sq[0] = r_s0;

    for (genvar k = 0; k < vtg_pkg::SQ_STEPS; k++) begin : g_sqrt
        vtg_sqrt_cell #(.STEP(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_sq    (w_sq[k]),
            .o_sq    (w_sq[k+1])
        );
    end

    // scale by 256 and fold left-half vectors by half a turn
    vtg_pkg::t_sq                     sq_end;
    vtg_pkg::t_cr                     r_pre;
    logic signed [vtg_pkg::VEC_W-1:0] ux0, uy0, vx0, vy0;

    assign sq_end = w_sq[vtg_pkg::SQ_STEPS];

    always_comb begin
        ux0 = {{3{sq_end.px[15]}}, sq_end.px, 8'd0};
        uy0 = {{3{sq_end.pz[15]}}, sq_end.pz, 8'd0};
        vx0 = {{3{sq_end.py[15]}}, sq_end.py, 8'd0};
        vy0 = {4'd0, sq_end.root[14:0], 8'd0};
    end

    always_ff @(posedge i_clk) begin
        r_pre.idx <= sq_end.idx;
        if (ux0 < 0) begin
            r_pre.ux <= -ux0;
            r_pre.uy <= -uy0;
            r_pre.ua <= vtg_pkg::HALF_TURN;
        end else begin
            r_pre.ux <= ux0;
            r_pre.uy <= uy0;
            r_pre.ua <= 32'd0;
        end
        if (vx0 < 0) begin
            r_pre.vx <= -vx0;
            r_pre.vy <= -vy0;
            r_pre.va <= vtg_pkg::HALF_TURN;
        end else begin
            r_pre.vx <= vx0;
            r_pre.vy <= vy0;
            r_pre.va <= 32'd0;
        end
        if (!i_rst_n) begin
            r_pre.vld <= 1'b0;
        end else begin
            r_pre.vld <= sq_end.vld;
        end
    end

    vtg_pkg::t_cr w_cr [0:ANGLE_STAGES];
    assign w_cr[0] = r_pre;

    for (genvar s = 0; s < ANGLE_STAGES; s++) begin : g_angle
        vtg_cordic_cell #(.STAGE(s)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cr    (w_cr[s]),
            .o_cr    (w_cr[s+1])
        );
    end

    vtg_pkg::t_cr cr_end;
    assign cr_end = w_cr[ANGLE_STAGES];

    logic        r_mu_vld;
    logic [15:0] r_mu_idx;
    logic [47:0] r_pu;
    logic [47:0] r_pv;

    always_ff @(posedge i_clk) begin
        r_mu_idx <= cr_end.idx;
        r_pu     <= cr_end.ua * r_scale_x;
        r_pv     <= cr_end.va * r_scale_y;
        if (!i_rst_n) begin
            r_mu_vld <= 1'b0;
        end else begin
            r_mu_vld <= cr_end.vld;
        end
    end

    // round, saturate and pick the mode
    logic [48:0]      sum_u, sum_v;
    logic [16:0]      ru, rv;
    logic [3:0]       cc;
    logic [1:0]       pc;
    logic [17:0]      cube_u, cube_v;
    logic [15:0]      sel_u, sel_v;
    vtg_pkg::t_result n_res;
    vtg_pkg::t_result r_res;
    logic             r_done;

    always_comb begin
        sum_u = {1'b0, r_pu} + (49'(1) << 32);
        sum_v = {1'b0, r_pv} + (49'(1) << 31);
        ru    = {1'b0, sum_u[48:33]};
        rv    = sum_v[48:32];
        cc    = vtg_pkg::cube_code(r_mu_idx[4:0]);
        pc    = vtg_pkg::plane_code(r_mu_idx[1:0]);
        case (cc[3:2])
            vtg_pkg::CC_X: sel_u = r_scale_x;
            vtg_pkg::CC_Y: sel_u = r_scale_y;
            vtg_pkg::CC_Z: sel_u = r_scale_z;
            default:       sel_u = 16'd0;
        endcase
        case (cc[1:0])
            vtg_pkg::CC_X: sel_v = r_scale_x;
            vtg_pkg::CC_Y: sel_v = r_scale_y;
            vtg_pkg::CC_Z: sel_v = r_scale_z;
            default:       sel_v = 16'd0;
        endcase
        cube_u = (18'(sel_u) + 18'd2) >> 2;
        cube_v = (18'(sel_v) + 18'd2) >> 2;
        n_res  = '0;
        case (r_mode)
            vtg_pkg::MODE_SPHERE: begin
                n_res.tex_u       = ru[16] ? 16'hFFFF : ru[15:0];
                n_res.tex_v       = rv[16] ? 16'hFFFF : rv[15:0];
                n_res.coord_valid = 1'b1;
            end
            vtg_pkg::MODE_CUBE: begin
                if (r_mu_idx < 16'd24) begin
                    n_res.tex_u       = cube_u[15:0];
                    n_res.tex_v       = cube_v[15:0];
                    n_res.coord_valid = 1'b1;
                end
            end
            vtg_pkg::MODE_PLANE: begin
                if (r_mu_idx < 16'd4) begin
                    n_res.tex_u       = pc[1] ? vtg_pkg::PLANE_TILE : 16'd0;
                    n_res.tex_v       = pc[0] ? vtg_pkg::PLANE_TILE : 16'd0;
                    n_res.coord_valid = 1'b1;
                end
            end
            default: n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_mu_vld;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

### hdl/vtg_checker.sv
module vtg_checker #(
    parameter int ANGLE_STAGES = 16
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              o_busy,
    input logic              o_done,
    input vtg_pkg::t_result  o_result
);

    localparam int LAT = ANGLE_STAGES + 19;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done && o_busy)
        else $error("result or ready right after reset");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.coord_valid |-> o_result.tex_u == 16'd0 &&
            o_result.tex_v == 16'd0)
        else $error("invalid result carries a coordinate");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, LAT))
        else $error("result without a request at fixed latency");

endmodule

bind vertex_texcoord_generator vtg_checker #(.ANGLE_STAGES(ANGLE_STAGES)) u_vtg_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_result (o_result)
);
